### sv/scb_pkg.sv
// Shared constants and types for the spectrum column ballistics block.
// No dependencies; the interfaces, the top level and the bench use it.
package scb_pkg;

  localparam int COLUMNS_DEF   = 720;
  localparam int MAX_FRAME_DEF = 4096;

  localparam int COL_W   = 10;
  localparam int MAG_W   = 32;
  localparam int FRAME_W = 13;
  localparam int DB_W    = 16;
  localparam int TIME_W  = 24;
  localparam int NUM_W   = 24;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 2'd0,
    REG_RELEASE = 2'd1,
    REG_RAW_REF = 2'd2
  } cfg_reg_t;

  localparam logic signed [DB_W-1:0] DB_FLOOR   = -16'sd19200;
  localparam logic signed [DB_W-1:0] RAW_OFFSET = 16'sd193;
  localparam logic [10:0]            TRAVEL_24DB = 11'd1536;

  // round(1280*log10(2) * 2^24), and the log value of 1.0 in Q8.24 times it
  localparam logic [32:0] LOG10_K  = 33'd6464569932;
  localparam logic [16:0] K_HI     = LOG10_K[32:16];
  localparam logic [15:0] K_LO     = LOG10_K[15:0];
  localparam logic [61:0] LOG_ZERO = 62'((64'd24 << 24) * 64'd6464569932);
  localparam logic [61:0] ROUND_HALF = 62'(64'd1 << 47);

endpackage

### sv/scb_if.sv
// Valid/ready channel interfaces: input items, results, register writes.
// Depends on scb_pkg for field widths.
interface scb_item_if;
  logic                         valid;
  logic                         ready;
  logic [scb_pkg::COL_W-1:0]    column;
  logic [scb_pkg::MAG_W-1:0]    magnitude;
  logic [scb_pkg::FRAME_W-1:0]  frame_samples;
  modport source (output valid, column, magnitude, frame_samples, input ready);
  modport sink   (input valid, column, magnitude, frame_samples, output ready);
endinterface

interface scb_result_if;
  logic                             valid;
  logic                             ready;
  logic [scb_pkg::COL_W-1:0]        out_column;
  logic signed [scb_pkg::DB_W-1:0]  display_db;
  modport source (output valid, out_column, display_db, input ready);
  modport sink   (input valid, out_column, display_db, output ready);
endinterface

interface scb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [scb_pkg::CFG_IDX_W-1:0]  index;
  logic [scb_pkg::TIME_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/scb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 720
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### sv/spectrum_column_ballistics.sv
// Top level: dB conversion pipeline, travel dividers and per-column level RAM.
// Depends on scb_pkg, scb_if.sv and scb_ram.
//
//   channel  dir  beat
//   item     in   column, magnitude, frame_samples
//   result   out  out_column, display_db (one per item)
//   cfg      in   index, data (always ready)
//
// One item per cycle while the skid entry is empty. The log2 unit is 24 squaring
// stages and the travel dividers 24 restoring stages running alongside it.
// The held level is read in the cycle before the update and written back; a
// write to the same column in the cycle of the read is forwarded.
// After reset a clearing pass sets every level to the floor;
// items are refused meanwhile. A two-entry output skid takes the result stall.
module spectrum_column_ballistics #(
  parameter int COLUMNS   = scb_pkg::COLUMNS_DEF,
  parameter int MAX_FRAME = scb_pkg::MAX_FRAME_DEF
) (
  input  logic      clk,
  input  logic      rst,
  scb_cfg_if.sink   cfg,
  scb_item_if.sink  item,
  scb_result_if.source result
);
  localparam int AW   = COLUMNS > 1 ? $clog2(COLUMNS) : 1;
  localparam int LAST = 31;

  typedef struct packed {
    logic                            v;
    logic [scb_pkg::COL_W-1:0]       col;
    logic                            ok;
    logic                            zero;
    logic                            frame_nz;
    logic [31:0]                     mag;
    logic [4:0]                      e;
    logic [31:0]                     mant;
    logic [28:0]                     u;
    logic [scb_pkg::NUM_W-1:0]       num;
    logic [scb_pkg::NUM_W-1:0]       rem_a;
    logic [scb_pkg::NUM_W-1:0]       q_a;
    logic [scb_pkg::NUM_W-1:0]       rem_r;
    logic [scb_pkg::NUM_W-1:0]       q_r;
    logic [30:0]                     pp0;
    logic [29:0]                     pp1;
    logic [31:0]                     pp2;
    logic [30:0]                     pp3;
    logic [61:0]                     p;
    logic [61:0]                     diff;
    logic                            neg;
    logic signed [scb_pkg::DB_W-1:0] target;
  } stage_t;

  typedef struct packed {
    logic [scb_pkg::COL_W-1:0]       col;
    logic signed [scb_pkg::DB_W-1:0] db;
  } beat_t;

  logic [scb_pkg::TIME_W-1:0] attack;
  logic [scb_pkg::TIME_W-1:0] release_t;
  logic                       raw_ref;

  stage_t pipe      [0:LAST];
  stage_t pipe_next [1:LAST];

  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          advance;

  logic          skid_v;
  beat_t         skid;
  logic          main_v;
  beat_t         main;

  logic                       last_we;
  logic [AW-1:0]              last_col;
  logic signed [scb_pkg::DB_W-1:0] last_val;
  logic [scb_pkg::DB_W-1:0]   rd_data;

  function automatic logic [4:0] top_bit(input logic [31:0] m);
    logic [4:0] e;
    e = '0;
    for (int i = 0; i < 32; i++) begin
      if (m[i]) e = 5'(i);
    end
    return e;
  endfunction

  function automatic stage_t stage_step(input int k, input stage_t a,
                                        input logic [scb_pkg::TIME_W-1:0] ta,
                                        input logic [scb_pkg::TIME_W-1:0] tr);
    stage_t     r;
    logic [24:0] ra;
    logic [24:0] rr;
    logic [63:0] sq;
    logic [13:0] mag14;
    logic [61:0] rnd;
    r = a;
    if (k >= 1 && k <= scb_pkg::NUM_W) begin
      // one restoring division step for each direction
      ra = {a.rem_a, a.num[scb_pkg::NUM_W-1]};
      rr = {a.rem_r, a.num[scb_pkg::NUM_W-1]};
      r.num = {a.num[scb_pkg::NUM_W-2:0], 1'b0};
      if (ra >= {1'b0, ta}) begin
        ra = ra - {1'b0, ta};
        r.q_a = {a.q_a[scb_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r.q_a = {a.q_a[scb_pkg::NUM_W-2:0], 1'b0};
      end
      if (rr >= {1'b0, tr}) begin
        rr = rr - {1'b0, tr};
        r.q_r = {a.q_r[scb_pkg::NUM_W-2:0], 1'b1};
      end else begin
        r.q_r = {a.q_r[scb_pkg::NUM_W-2:0], 1'b0};
      end
      r.rem_a = ra[scb_pkg::NUM_W-1:0];
      r.rem_r = rr[scb_pkg::NUM_W-1:0];
    end
    if (k == 1) begin
      r.e = top_bit(a.mag);
    end
    if (k == 2) begin
      r.mant = a.mag << (5'd31 - a.e);
      r.u    = 29'(a.e);
    end
    if (k >= 3 && k <= 26) begin
      // square the Q1.31 mantissa; a square at or above 2.0 gives a one bit
      sq = 64'(a.mant) * 64'(a.mant);
      if (sq[63]) begin
        r.u    = {a.u[27:0], 1'b1};
        r.mant = sq[63:32];
      end else begin
        r.u    = {a.u[27:0], 1'b0};
        r.mant = sq[62:31];
      end
    end
    if (k == 27) begin
      r.pp0 = 31'(a.u[28:15]) * 31'(scb_pkg::K_HI);
      r.pp1 = 30'(a.u[28:15]) * 30'(scb_pkg::K_LO);
      r.pp2 = 32'(a.u[14:0])  * 32'(scb_pkg::K_HI);
      r.pp3 = 31'(a.u[14:0])  * 31'(scb_pkg::K_LO);
    end
    if (k == 28) begin
      r.p = (62'(a.pp0) << 31) + (62'(a.pp1) << 15) + (62'(a.pp2) << 16) + 62'(a.pp3);
    end
    if (k == 29) begin
      if (a.p >= scb_pkg::LOG_ZERO) begin
        r.diff = a.p - scb_pkg::LOG_ZERO;
        r.neg  = 1'b0;
      end else begin
        r.diff = scb_pkg::LOG_ZERO - a.p;
        r.neg  = 1'b1;
      end
    end
    if (k == 30) begin
      rnd   = a.diff + scb_pkg::ROUND_HALF;
      mag14 = rnd[61:48];
      if (a.zero) begin
        r.target = scb_pkg::DB_FLOOR;
      end else if (a.neg) begin
        r.target = -$signed(16'(mag14));
      end else begin
        r.target = $signed(16'(mag14));
      end
    end
    return r;
  endfunction

  assign advance    = !skid_v;
  assign item.ready = advance && !clearing;
  assign cfg.ready  = 1'b1;

  always_comb begin
    for (int k = 1; k <= LAST; k++) begin
      pipe_next[k] = stage_step(k, pipe[k-1], attack, release_t);
    end
  end

  // update stage: forwarded or stored level moves toward the target; out-of-range columns give the floor
  logic signed [scb_pkg::DB_W-1:0] held;
  logic signed [scb_pkg::DB_W-1:0] tgt;
  logic                            rising;
  logic [scb_pkg::TIME_W-1:0]      t_sel;
  logic [scb_pkg::NUM_W-1:0]       q_sel;
  logic [15:0]                     travel;
  logic signed [17:0]              up;
  logic signed [17:0]              down;
  logic signed [scb_pkg::DB_W-1:0] moved;
  logic signed [scb_pkg::DB_W-1:0] level;
  beat_t                           new_beat;
  logic                            push;
  logic                            pop;
  logic [AW-1:0]                   upd_addr;

  assign upd_addr = AW'(pipe[LAST].col);

  always_comb begin
    held   = (last_we && last_col == upd_addr) ? last_val : $signed(rd_data);
    tgt    = pipe[LAST].target;
    rising = tgt > held;
    t_sel  = rising ? attack : release_t;
    q_sel  = rising ? pipe[LAST].q_a : pipe[LAST].q_r;
    travel = (q_sel > 24'd65535) ? 16'hFFFF : q_sel[15:0];
    up     = 18'(held) + $signed({2'b00, travel});
    down   = 18'(held) - $signed({2'b00, travel});
    if (!pipe[LAST].frame_nz || tgt == held) begin
      moved = held;
    end else if (t_sel == '0) begin
      moved = tgt;
    end else if (rising) begin
      moved = (up > 18'(tgt)) ? tgt : up[15:0];
    end else begin
      moved = (down < 18'(tgt)) ? tgt : down[15:0];
    end
    level        = pipe[LAST].ok ? moved : scb_pkg::DB_FLOOR;
    new_beat.col = pipe[LAST].col;
    new_beat.db  = level - (raw_ref ? scb_pkg::RAW_OFFSET : 16'sd0);
  end

  assign push = advance && pipe[LAST].v;
  assign pop  = main_v && result.ready;

  scb_ram #(
    .WIDTH (scb_pkg::DB_W),
    .DEPTH (COLUMNS)
  ) u_level_ram (
    .clk   (clk),
    .we    (clearing || (push && pipe[LAST].ok)),
    .waddr (clearing ? clr_addr : upd_addr),
    .wdata (clearing ? scb_pkg::DB_FLOOR : level),
    .re    (advance),
    .raddr (AW'(pipe[LAST-1].col)),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attack    <= '0;
      release_t <= '0;
      raw_ref   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        scb_pkg::REG_ATTACK:  attack    <= cfg.data;
        scb_pkg::REG_RELEASE: release_t <= cfg.data;
        scb_pkg::REG_RAW_REF: raw_ref   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(COLUMNS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  logic [scb_pkg::FRAME_W-1:0] frame_sat;
  assign frame_sat = (32'(item.frame_samples) > MAX_FRAME) ?
                     scb_pkg::FRAME_W'(MAX_FRAME) : item.frame_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        pipe[k].v <= 1'b0;
      end
    end else if (advance) begin
      pipe[0].v        <= item.valid && item.ready;
      pipe[0].col      <= item.column;
      pipe[0].ok       <= 32'(item.column) < COLUMNS;
      pipe[0].zero     <= item.magnitude == '0;
      pipe[0].frame_nz <= frame_sat != '0;
      pipe[0].mag      <= item.magnitude;
      pipe[0].num      <= scb_pkg::NUM_W'(frame_sat) * scb_pkg::NUM_W'(scb_pkg::TRAVEL_24DB);
      pipe[0].rem_a    <= '0;
      pipe[0].q_a      <= '0;
      pipe[0].rem_r    <= '0;
      pipe[0].q_r      <= '0;
      for (int k = 1; k <= LAST; k++) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_we <= 1'b0;
    end else if (advance) begin
      last_we  <= push && pipe[LAST].ok;
      last_col <= upd_addr;
      last_val <= level;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (pop || !main_v) begin
      main_v <= skid_v || push;
      main   <= skid_v ? skid : new_beat;
      skid_v <= 1'b0;
    end else if (push) begin
      skid   <= new_beat;
      skid_v <= 1'b1;
    end
  end

  assign result.valid      = main_v;
  assign result.out_column = main.col;
  assign result.display_db = main.db;

endmodule

### bench/tb_spectrum_column_ballistics.sv
// Testbench for spectrum_column_ballistics: directed table, then random beats, checked
// against an in-bench ballistics predictor or a fixed expected value. Depends on scb_pkg, scb_if.sv.
module tb_spectrum_column_ballistics;
  import scb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scb_cfg_if    cfg_ch();
  scb_item_if   item_ch();
  scb_result_if res_ch();

  spectrum_column_ballistics dut (
    .clk(clk), .rst(rst), .cfg(cfg_ch.sink), .item(item_ch.sink), .result(res_ch.source)
  );

  typedef struct {
    logic [COL_W-1:0]       col;
    logic signed [DB_W-1:0] db;
  } level_beat_t;

  typedef struct {
    logic [COL_W-1:0]   col;
    logic [MAG_W-1:0]   mag;
    logic [FRAME_W-1:0] frame;
    bit                 fixed;
    int                 db;
  } stim_row_t;

  logic signed [DB_W-1:0] held_q [COLUMNS_DEF];
  logic [TIME_W-1:0] attack_q, release_q;
  bit raw_q;
  level_beat_t pending_levels[$];
  int errors = 0;
  bit stall_long = 1'b0;
  bit drain_hold = 1'b0;

  function automatic int db_target(logic [31:0] m);
    int e;
    logic [63:0] mant, u, p, z;
    if (m == 0) return -19200;
    e = 31;
    while (!m[e]) e--;
    mant = 64'(m) << (31 - e);
    u = 64'(e);
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 31;
      u = u << 1;
      if (mant >= (64'd1 << 32)) begin
        u[0] = 1'b1;
        mant = mant >> 1;
      end
    end
    p = u * 64'd6464569932;
    z = (64'd24 << 24) * 64'd6464569932;
    if (p >= z) return int'((p - z + (64'd1 << 47)) >> 48);
    return -int'((z - p + (64'd1 << 47)) >> 48);
  endfunction

  function automatic level_beat_t predict_level(logic [9:0] col, logic [31:0] mag,
                                                logic [12:0] frame_in);
    level_beat_t r;
    int lvl, tgt, held, nxt;
    longint unsigned fr, t, trav;
    fr = (frame_in > MAX_FRAME_DEF) ? MAX_FRAME_DEF : frame_in;
    lvl = -19200;
    if (col < COLUMNS_DEF) begin
      tgt = db_target(mag);
      held = held_q[col];
      nxt = held;
      if (tgt != held && fr != 0) begin
        t = (tgt > held) ? attack_q : release_q;
        if (t == 0) nxt = tgt;
        else begin
          trav = (1536 * fr) / t;
          if (trav > 65535) trav = 65535;
          if (tgt > held) begin
            nxt = held + int'(trav);
            if (nxt > tgt) nxt = tgt;
          end else begin
            nxt = held - int'(trav);
            if (nxt < tgt) nxt = tgt;
          end
        end
      end
      held_q[col] = 16'(nxt);
      lvl = nxt;
    end
    r.col = col;
    r.db = 16'(lvl - (raw_q ? 193 : 0));
    return r;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [TIME_W-1:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ATTACK:  attack_q = val;
      REG_RELEASE: release_q = val;
      default:     raw_q = val[0];
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic send_item(logic [9:0] col, logic [31:0] mag, logic [12:0] fr,
                           bit fixed, int db);
    level_beat_t exp_beat;
    if ($urandom_range(3) == 0) repeat ($urandom_range(9) == 0 ? $urandom_range(60)
                                         : $urandom_range(3)) @(negedge clk);
    item_ch.valid = 1'b1;
    item_ch.column = col;
    item_ch.magnitude = mag;
    item_ch.frame_samples = fr;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    exp_beat = predict_level(col, mag, fr);
    if (fixed) exp_beat.db = 16'(db);
    pending_levels.push_back(exp_beat);
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_long) begin
        res_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
        stall_long = 1'b0;
      end else if ($urandom_range(15) == 0)
        res_ch.ready <= 1'b0;
      else if ($urandom_range(40) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(50)) @(negedge clk);
      end else
        res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    level_beat_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected result col %0d db %0d", $time,
                 res_ch.out_column, res_ch.display_db);
        errors++;
      end else begin
        e = pending_levels.pop_front();
        if (res_ch.out_column !== e.col) begin
          $display("%0t: out_column expected %0d actual %0d", $time, e.col,
                   res_ch.out_column);
          errors++;
        end
        if (res_ch.display_db !== e.db) begin
          $display("%0t: display_db expected %0d actual %0d", $time, e.db,
                   res_ch.display_db);
          errors++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    int col_pick;
    logic [31:0] m;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_ATTACK; cfg_ch.data = '0;
    item_ch.valid = 1'b0; item_ch.column = '0; item_ch.magnitude = '0;
    item_ch.frame_samples = '0;
    attack_q = 0; release_q = 0; raw_q = 0;
    foreach (held_q[i]) held_q[i] = -19200;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: col, mag, frame, fixed, expected db
    rows = '{
      '{10'd0,   32'h0,        13'd100,  1'b1, -19200},
      '{10'd1,   32'h0100_0000,13'd1,    1'b1, 0},
      '{10'd1,   32'h0100_0000,13'd0,    1'b1, 0},
      '{10'd2,   32'hFFFF_FFFF,13'd4096, 1'b0, 0},
      '{10'd719, 32'h0000_0001,13'd8191, 1'b0, 0},
      '{10'd720, 32'h1234_5678,13'd5,    1'b1, -19200},
      '{10'd1023,32'hFFFF_FFFF,13'd4096, 1'b1, -19200},
      '{10'd2,   32'h0,        13'd1,    1'b1, -19200},
      '{10'd3,   32'h8000_0000,13'd4097, 1'b0, 0}
    };
    foreach (rows[i]) send_item(rows[i].col, rows[i].mag, rows[i].frame, rows[i].fixed,
                                rows[i].db);
    wait_idle();
    write_reg(REG_ATTACK, 24'd1536);
    write_reg(REG_RELEASE, 24'hFF_FFFF);
    write_reg(REG_RAW_REF, 24'd1);
    send_item(10'd720, 32'h5, 13'd3, 1'b1, -19393);
    send_item(10'd4, 32'hFFFF_FFFF, 13'd4096, 1'b0, 0);
    send_item(10'd4, 32'h0, 13'd4096, 1'b0, 0);
    send_item(10'd4, 32'h0, 13'd0, 1'b0, 0);
    send_item(10'd1, 32'h0, 13'd8191, 1'b0, 0);
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(REG_ATTACK, ph == 5 ? 24'hFF_FFFF : (ph == 0 ? 24'd0 : 24'($urandom_range(20000))));
      write_reg(REG_RELEASE, ph == 4 ? 24'd1 : 24'($urandom));
      write_reg(REG_RAW_REF, 24'(ph[0]));
      if (ph == 2) stall_long = 1'b1;
      for (int k = 0; k < 85; k++) begin
        col_pick = ($urandom_range(19) == 0) ? $urandom_range(1023) : $urandom_range(15);
        case ($urandom_range(3))
          0: m = $urandom;
          1: m = $urandom >> $urandom_range(31);
          2: m = 0;
          default: m = 32'h0100_0000 + $urandom_range(255) - 128;
        endcase
        send_item(10'(col_pick), m,
                  ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(4096)),
                  1'b0, 0);
      end
    end
    wait_idle();
    if (errors == 0 && pending_levels.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

### spectrum_column_ballistics.f
sv/scb_pkg.sv
sv/scb_if.sv
sv/scb_ram.sv
sv/spectrum_column_ballistics.sv
bench/tb_spectrum_column_ballistics.sv
